// ===== design/bcpm_pkg.sv =====
// Shared types and constants for the balance cascade PID mixer.
// Beat structs, register map, register reset values and shared MAC unit controls.
// No dependencies.
package bcpm_pkg;

   // Configuration port
   localparam int CsrIdxW  = 4;
   localparam int CsrDataW = 18;

   typedef enum logic [CsrIdxW-1:0] {
      REG_TILT_LIMIT,
      REG_SETPOINT_LIMIT,
      REG_SPEED_P_GAIN,
      REG_SPEED_I_GAIN,
      REG_SPEED_D_GAIN,
      REG_ANGLE_P_GAIN,
      REG_ANGLE_I_GAIN,
      REG_ANGLE_D_GAIN
   } csr_reg_type;

   localparam logic [6:0]  TiltLimitReset     = 7'd30;
   localparam logic [6:0]  SetpointLimitReset = 7'd20;
   localparam logic [15:0] SpeedPGainReset    = 16'd2621;
   localparam logic [15:0] SpeedIGainReset    = 16'd1311;
   localparam logic [15:0] SpeedDGainReset    = 16'd6554;
   localparam logic [17:0] AnglePGainReset    = 18'd15360;
   localparam logic [17:0] AngleIGainReset    = 18'd76800;
   localparam logic [17:0] AngleDGainReset    = 18'd512;

   typedef struct packed {
      logic [6:0]  tilt_limit;
      logic [6:0]  setpoint_limit;
      logic [15:0] speed_p_gain;
      logic [15:0] speed_i_gain;
      logic [15:0] speed_d_gain;
      logic [17:0] angle_p_gain;
      logic [17:0] angle_i_gain;
      logic [17:0] angle_d_gain;
   } csr_type;

   // Beat payloads
   typedef struct packed {
      logic signed [16:0] tilt_angle;
      logic signed [19:0] tilt_rate;
      logic signed [7:0]  throttle;
      logic signed [7:0]  steering;
   } req_type;

   typedef struct packed {
      logic [9:0]         right_compare;
      logic [9:0]         left_compare;
      logic signed [15:0] tilt_setpoint;
      logic               active;
   } rsp_type;

   // Shared multiply-accumulate unit
   localparam int MacAW = 34;
   localparam int MacBW = 21;
   localparam int MacPW = MacAW + MacBW;
   localparam int AccW  = 60;

   // Gain products on errors and rate are scaled by 2^16
   localparam int GainShift = 16;
   // Angle integrator is fed to the multiplier as two 20-bit halves
   localparam int AiSplit   = 20;

   typedef enum logic [1:0] {
      MAC_HOLD,
      MAC_LOAD,
      MAC_ADD,
      MAC_SUB
   } mac_op_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_GAIN,
      SH_SPLIT
   } mac_shift_type;

   typedef struct packed {
      mac_op_type    op;
      mac_shift_type shift;
   } mac_ctl_type;

   // Trapezoid step s*8192/25: magnitude times ceil(2^37/25), top bits from 24 up
   localparam logic signed [MacAW-1:0] TrapRecip = 34'sd5497558139;
   localparam int TrapShift = 24;
   localparam int TrapMagW  = 28;

   // Output scaling of the two PID sums
   localparam int SpShift  = 24;
   localparam int DrvShift = 32;

endpackage

// ===== design/bcpm_csr.sv =====
// Configuration register file for the balance cascade PID mixer.
// Depends on bcpm_pkg for the register map, widths and reset values.
module bcpm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bcpm_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [bcpm_pkg::CsrDataW-1:0]  csr_wdata,
   output bcpm_pkg::csr_type              regs
);

   bcpm_pkg::csr_type regs_ff;
   bcpm_pkg::csr_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_we) begin
         case (csr_index)
            bcpm_pkg::REG_TILT_LIMIT:     regs_in.tilt_limit     = csr_wdata[6:0];
            bcpm_pkg::REG_SETPOINT_LIMIT: regs_in.setpoint_limit = csr_wdata[6:0];
            bcpm_pkg::REG_SPEED_P_GAIN:   regs_in.speed_p_gain   = csr_wdata[15:0];
            bcpm_pkg::REG_SPEED_I_GAIN:   regs_in.speed_i_gain   = csr_wdata[15:0];
            bcpm_pkg::REG_SPEED_D_GAIN:   regs_in.speed_d_gain   = csr_wdata[15:0];
            bcpm_pkg::REG_ANGLE_P_GAIN:   regs_in.angle_p_gain   = csr_wdata[17:0];
            bcpm_pkg::REG_ANGLE_I_GAIN:   regs_in.angle_i_gain   = csr_wdata[17:0];
            bcpm_pkg::REG_ANGLE_D_GAIN:   regs_in.angle_d_gain   = csr_wdata[17:0];
            default: ;  // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.tilt_limit     <= bcpm_pkg::TiltLimitReset;
         regs_ff.setpoint_limit <= bcpm_pkg::SetpointLimitReset;
         regs_ff.speed_p_gain   <= bcpm_pkg::SpeedPGainReset;
         regs_ff.speed_i_gain   <= bcpm_pkg::SpeedIGainReset;
         regs_ff.speed_d_gain   <= bcpm_pkg::SpeedDGainReset;
         regs_ff.angle_p_gain   <= bcpm_pkg::AnglePGainReset;
         regs_ff.angle_i_gain   <= bcpm_pkg::AngleIGainReset;
         regs_ff.angle_d_gain   <= bcpm_pkg::AngleDGainReset;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

// ===== design/bcpm_mac.sv =====
// Shared signed multiply-accumulate unit of the balance cascade PID mixer.
// Depends on bcpm_pkg for operand widths and the control struct.
module bcpm_mac (
   input  logic                                clock,
   input  bcpm_pkg::mac_ctl_type               ctl,
   input  logic signed [bcpm_pkg::MacAW-1:0]   op_a,
   input  logic signed [bcpm_pkg::MacBW-1:0]   op_b,
   output logic signed [bcpm_pkg::AccW-1:0]    acc
);

   logic signed [bcpm_pkg::MacPW-1:0] prod;
   logic signed [bcpm_pkg::AccW-1:0]  prod_ext;
   logic signed [bcpm_pkg::AccW-1:0]  term;
   logic signed [bcpm_pkg::AccW-1:0]  acc_ff;
   logic signed [bcpm_pkg::AccW-1:0]  acc_in;

   assign prod     = op_a * op_b;
   assign prod_ext = {{(bcpm_pkg::AccW - bcpm_pkg::MacPW){prod[bcpm_pkg::MacPW-1]}}, prod};

   always_comb begin
      case (ctl.shift)
         bcpm_pkg::SH_GAIN:  term = prod_ext <<< bcpm_pkg::GainShift;
         bcpm_pkg::SH_SPLIT: term = prod_ext <<< bcpm_pkg::AiSplit;
         default:            term = prod_ext;
      endcase
   end

   always_comb begin
      case (ctl.op)
         bcpm_pkg::MAC_LOAD: acc_in = term;
         bcpm_pkg::MAC_ADD:  acc_in = acc_ff + term;
         bcpm_pkg::MAC_SUB:  acc_in = acc_ff - term;
         default:            acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== design/bcpm_mix.sv =====
// Steering mixer: turns drive and steering into the two PWM compare values.
// Combinational; no package dependency.
module bcpm_mix (
   input  logic signed [10:0] drive,
   input  logic signed [7:0]  throttle,
   input  logic signed [7:0]  steering,
   output logic [9:0]         right_compare,
   output logic [9:0]         left_compare
);

   logic signed [9:0]  st3;
   logic signed [9:0]  st_half;
   logic signed [11:0] steer;
   logic signed [11:0] neg_drive;
   logic signed [11:0] vr;
   logic signed [11:0] vl;
   logic               small_thr;

   // 3*steering/2, truncated toward zero
   assign st3       = (10'(steering) <<< 1) + 10'(steering);
   assign st_half   = (st3 + (st3[9] ? 10'sd1 : 10'sd0)) >>> 1;
   assign steer     = 12'(st_half);
   assign neg_drive = -12'(drive);
   assign small_thr = (throttle >= -8'sd2) && (throttle <= 8'sd2);

   // Near-zero throttle spins in place; otherwise only the outer wheel steers
   always_comb begin
      if (small_thr) begin
         vr = steer + neg_drive;
         vl = neg_drive - steer;
      end else if (steering > 8'sd0) begin
         vr = steer + neg_drive;
         vl = neg_drive;
      end else begin
         vr = neg_drive;
         vl = neg_drive - steer;
      end
   end

   function automatic logic [9:0] to_compare(input logic signed [11:0] v);
      logic signed [11:0] sum;
      sum = v + 12'sd500;
      if (v < -12'sd500) begin
         return 10'd0;
      end
      if (v > 12'sd499) begin
         return 10'd999;
      end
      return sum[9:0];
   endfunction

   assign right_compare = to_compare(vr);
   assign left_compare  = to_compare(vl);

endmodule

// ===== design/balance_cascade_pid_mixer_core.sv =====
// Top level of the balance cascade PID mixer: sequencer, loop state and output register.
// Depends on bcpm_pkg, bcpm_csr, bcpm_mac and bcpm_mix.
//
//   channel  ports                          direction  beat
//   req      req_valid req_stall req_data    in         one control tick
//   rsp      rsp_valid rsp_stall rsp_data    out        compares, setpoint, active
//   csr      csr_we csr_index csr_wdata      in         one register write
//
// An active tick (tilt inside the limit) runs from accept to the next accept as follows:
// the sequencer walks 14 steps through the one shared multiply-accumulate unit, then loads
// the output register. An inactive tick goes straight from accept to loading the output register.
// req_stall is high while a tick is in work; the output register holds a finished beat
// under rsp_stall while the next tick is taken, and the sequencer waits in its last step
// only if a second result is ready before the first is taken.
// Reset is synchronous, active high; it restores register defaults and clears loop state.
module balance_cascade_pid_mixer_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bcpm_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bcpm_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [bcpm_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [bcpm_pkg::CsrDataW-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,   // wait for a tick
      ST_FILT,   // low-pass drive, form speed error
      ST_STRAP,  // speed trapezoid step through the MAC
      ST_SINT,   // saturate speed integrator
      ST_SP,     // speed P term
      ST_SI,     // speed I term
      ST_SD,     // speed D term
      ST_SPC,    // setpoint clamp, form angle error
      ST_ATRAP,  // angle trapezoid step through the MAC
      ST_AINT,   // saturate angle integrator
      ST_AP,     // angle P term
      ST_AIL,    // angle I term, low half of integrator
      ST_AIH,    // angle I term, high half of integrator
      ST_AD,     // angle D term on the rate
      ST_DRV,    // scale and clamp drive
      ST_MIX     // mix and load output register
   } state_type;

   bcpm_pkg::csr_type csr;

   state_type state_ff, state_in;

   // Latched tick
   logic               active_ff, active_in;
   logic signed [16:0] angle_ff, angle_in;
   logic signed [19:0] rate_ff, rate_in;
   logic signed [7:0]  thr_ff, thr_in;
   logic signed [7:0]  st_ff, st_in;

   // Loop state
   logic signed [10:0] filt_ff, filt_in;
   logic signed [10:0] spd_err_last_ff, spd_err_last_in;
   logic signed [31:0] spd_int_ff, spd_int_in;
   logic signed [17:0] ang_err_last_ff, ang_err_last_in;
   logic signed [39:0] ang_int_ff, ang_int_in;
   logic signed [10:0] drive_ff, drive_in;
   logic signed [15:0] setpoint_ff, setpoint_in;

   // Working registers
   logic signed [10:0] e_ff, e_in;
   logic signed [11:0] ediff_ff, ediff_in;
   logic signed [17:0] ae_ff, ae_in;
   logic [18:0]        sum_abs_ff, sum_abs_in;
   logic               sum_neg_ff, sum_neg_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   bcpm_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   // Shared unit
   bcpm_pkg::mac_ctl_type                mac_ctl;
   logic signed [bcpm_pkg::MacAW-1:0]    mac_a;
   logic signed [bcpm_pkg::MacBW-1:0]    mac_b;
   logic signed [bcpm_pkg::AccW-1:0]     acc;

   // Mixer
   logic [9:0] mix_right;
   logic [9:0] mix_left;

   bcpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (csr)
   );

   bcpm_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (acc)
   );

   bcpm_mix u_mix (
      .drive         (drive_ff),
      .throttle      (thr_ff),
      .steering      (st_ff),
      .right_compare (mix_right),
      .left_compare  (mix_left)
   );

   // Tilt window: strictly inside +-tilt_limit degrees
   logic [14:0]        lim;
   logic signed [17:0] lim_s;
   logic signed [17:0] angle_s;
   logic               active_now;

   assign lim        = {csr.tilt_limit, 8'b0};
   assign lim_s      = 18'(lim);
   assign angle_s    = 18'(req_data.tilt_angle);
   assign active_now = (angle_s < lim_s) && (angle_s > -lim_s);

   // Drive low-pass: (7f + d)/8 toward zero
   logic signed [12:0] filt_sum;
   logic signed [12:0] filt_bias;
   logic signed [10:0] filt_new;
   logic signed [10:0] e_new;
   logic signed [11:0] spd_sum;

   assign filt_sum  = (13'(filt_ff) <<< 3) - 13'(filt_ff) + 13'(drive_ff);
   assign filt_bias = filt_sum + (filt_sum[12] ? 13'sd7 : 13'sd0);
   assign filt_new  = 11'(filt_bias >>> 3);
   assign e_new     = 11'((12'(thr_ff) <<< 1) - 12'(filt_new));
   assign spd_sum   = 12'(e_new) + 12'(spd_err_last_ff);

   // Trapezoid step from the MAC, signed back
   logic [bcpm_pkg::TrapMagW-1:0] step_mag;
   logic [bcpm_pkg::TrapMagW:0]   step_u;
   logic signed [28:0]            step;
   logic signed [32:0]            spd_int_sum;
   logic signed [40:0]            ang_int_sum;
   logic signed [31:0]            spd_int_sat;
   logic signed [39:0]            ang_int_sat;

   assign step_mag    = acc[bcpm_pkg::TrapShift + bcpm_pkg::TrapMagW - 1:bcpm_pkg::TrapShift];
   assign step_u      = {1'b0, step_mag};
   assign step        = sum_neg_ff ? -$signed(step_u) : $signed(step_u);
   assign spd_int_sum = 33'(spd_int_ff) + 33'(step);
   assign ang_int_sum = 41'(ang_int_ff) + 41'(step);

   // Saturate integrators on overflow of the sum's top bit
   always_comb begin
      if (spd_int_sum[32] != spd_int_sum[31]) begin
         spd_int_sat = spd_int_sum[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
         spd_int_sat = spd_int_sum[31:0];
      end
      if (ang_int_sum[40] != ang_int_sum[39]) begin
         ang_int_sat = ang_int_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
      end else begin
         ang_int_sat = ang_int_sum[39:0];
      end
   end

   // Setpoint: acc / 2^24 toward zero, clamp to +-setpoint_limit degrees
   logic signed [bcpm_pkg::AccW-1:0]               sp_round;
   logic signed [bcpm_pkg::AccW-bcpm_pkg::SpShift-1:0] sp_q;
   logic [14:0]                                    spl;
   logic signed [bcpm_pkg::AccW-bcpm_pkg::SpShift-1:0] spl_s;
   logic signed [15:0]                             sp_new;
   logic signed [17:0]                             ae_new;
   logic signed [18:0]                             ang_sum;

   assign sp_round = acc + $signed({{(bcpm_pkg::AccW - bcpm_pkg::SpShift){1'b0}},
                                    {bcpm_pkg::SpShift{acc[bcpm_pkg::AccW-1]}}});
   assign sp_q     = sp_round[bcpm_pkg::AccW-1:bcpm_pkg::SpShift];
   assign spl      = {csr.setpoint_limit, 8'b0};
   assign spl_s    = $signed({{(bcpm_pkg::AccW - bcpm_pkg::SpShift - 15){1'b0}}, spl});

   always_comb begin
      if (sp_q > spl_s) begin
         sp_new = 16'(spl_s);
      end else if (sp_q < -spl_s) begin
         sp_new = 16'(-spl_s);
      end else begin
         sp_new = 16'(sp_q);
      end
   end

   assign ae_new  = 18'(sp_new) - 18'(angle_ff);
   assign ang_sum = 19'(ae_new) + 19'(ang_err_last_ff);

   // Drive: -(acc / 2^32 toward zero), clamped to -499..500
   logic signed [bcpm_pkg::AccW-1:0]                    u_round;
   logic signed [bcpm_pkg::AccW-bcpm_pkg::DrvShift-1:0] u_q;
   logic signed [10:0]                                  drive_new;

   assign u_round = acc + $signed({{(bcpm_pkg::AccW - bcpm_pkg::DrvShift){1'b0}},
                                   {bcpm_pkg::DrvShift{acc[bcpm_pkg::AccW-1]}}});
   assign u_q     = u_round[bcpm_pkg::AccW-1:bcpm_pkg::DrvShift];

   always_comb begin
      if (u_q > 28'sd499) begin
         drive_new = -11'sd499;
      end else if (u_q < -28'sd500) begin
         drive_new = 11'sd500;
      end else begin
         drive_new = 11'(-u_q);
      end
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      active_in       = active_ff;
      angle_in        = angle_ff;
      rate_in         = rate_ff;
      thr_in          = thr_ff;
      st_in           = st_ff;
      filt_in         = filt_ff;
      spd_err_last_in = spd_err_last_ff;
      spd_int_in      = spd_int_ff;
      ang_err_last_in = ang_err_last_ff;
      ang_int_in      = ang_int_ff;
      drive_in        = drive_ff;
      setpoint_in     = setpoint_ff;
      e_in            = e_ff;
      ediff_in        = ediff_ff;
      ae_in           = ae_ff;
      sum_abs_in      = sum_abs_ff;
      sum_neg_in      = sum_neg_ff;
      rsp_data_in     = rsp_data_ff;
      mac_ctl         = '{op: bcpm_pkg::MAC_HOLD, shift: bcpm_pkg::SH_NONE};
      mac_a           = '0;
      mac_b           = '0;

      // Drop the held beat once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               active_in = active_now;
               angle_in  = req_data.tilt_angle;
               rate_in   = req_data.tilt_rate;
               thr_in    = req_data.throttle;
               st_in     = req_data.steering;
               if (active_now) begin
                  state_in = ST_FILT;
               end else begin
                  // Out of the window: clear integrators and drive, keep the rest
                  spd_int_in = '0;
                  ang_int_in = '0;
                  drive_in   = '0;
                  state_in   = ST_MIX;
               end
            end
         end
         ST_FILT: begin
            filt_in         = filt_new;
            e_in            = e_new;
            ediff_in        = 12'(e_new) - 12'(spd_err_last_ff);
            spd_err_last_in = e_new;
            sum_neg_in      = spd_sum[11];
            sum_abs_in      = 19'(spd_sum[11] ? -spd_sum : spd_sum);
            state_in        = ST_STRAP;
         end
         ST_STRAP: begin
            mac_ctl  = '{op: bcpm_pkg::MAC_LOAD, shift: bcpm_pkg::SH_NONE};
            mac_a    = bcpm_pkg::TrapRecip;
            mac_b    = $signed({2'b0, sum_abs_ff});
            state_in = ST_SINT;
         end
         ST_SINT: begin
            spd_int_in = spd_int_sat;
            state_in   = ST_SP;
         end
         ST_SP: begin
            mac_ctl  = '{op: bcpm_pkg::MAC_LOAD, shift: bcpm_pkg::SH_GAIN};
            mac_a    = 34'(e_ff);
            mac_b    = $signed(21'(csr.speed_p_gain));
            state_in = ST_SI;
         end
         ST_SI: begin
            mac_ctl  = '{op: bcpm_pkg::MAC_ADD, shift: bcpm_pkg::SH_NONE};
            mac_a    = 34'(spd_int_ff);
            mac_b    = $signed(21'(csr.speed_i_gain));
            state_in = ST_SD;
         end
         ST_SD: begin
            mac_ctl  = '{op: bcpm_pkg::MAC_SUB, shift: bcpm_pkg::SH_GAIN};
            mac_a    = 34'(ediff_ff);
            mac_b    = $signed(21'(csr.speed_d_gain));
            state_in = ST_SPC;
         end
         ST_SPC: begin
            setpoint_in     = sp_new;
            ae_in           = ae_new;
            ang_err_last_in = ae_new;
            sum_neg_in      = ang_sum[18];
            sum_abs_in      = 19'(ang_sum[18] ? -ang_sum : ang_sum);
            state_in        = ST_ATRAP;
         end
         ST_ATRAP: begin
            mac_ctl  = '{op: bcpm_pkg::MAC_LOAD, shift: bcpm_pkg::SH_NONE};
            mac_a    = bcpm_pkg::TrapRecip;
            mac_b    = $signed({2'b0, sum_abs_ff});
            state_in = ST_AINT;
         end
         ST_AINT: begin
            ang_int_in = ang_int_sat;
            state_in   = ST_AP;
         end
         ST_AP: begin
            mac_ctl  = '{op: bcpm_pkg::MAC_LOAD, shift: bcpm_pkg::SH_GAIN};
            mac_a    = 34'(ae_ff);
            mac_b    = $signed(21'(csr.angle_p_gain));
            state_in = ST_AIL;
         end
         ST_AIL: begin
            // Low half is unsigned, high half carries the sign
            mac_ctl  = '{op: bcpm_pkg::MAC_ADD, shift: bcpm_pkg::SH_NONE};
            mac_a    = $signed({{(bcpm_pkg::MacAW - bcpm_pkg::AiSplit){1'b0}},
                                ang_int_ff[bcpm_pkg::AiSplit-1:0]});
            mac_b    = $signed(21'(csr.angle_i_gain));
            state_in = ST_AIH;
         end
         ST_AIH: begin
            mac_ctl  = '{op: bcpm_pkg::MAC_ADD, shift: bcpm_pkg::SH_SPLIT};
            mac_a    = 34'($signed(ang_int_ff[39:bcpm_pkg::AiSplit]));
            mac_b    = $signed(21'(csr.angle_i_gain));
            state_in = ST_AD;
         end
         ST_AD: begin
            mac_ctl  = '{op: bcpm_pkg::MAC_SUB, shift: bcpm_pkg::SH_GAIN};
            mac_a    = 34'(rate_ff);
            mac_b    = $signed(21'(csr.angle_d_gain));
            state_in = ST_DRV;
         end
         ST_DRV: begin
            drive_in = drive_new;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            // Advance only when the output register is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.right_compare = mix_right;
               rsp_data_in.left_compare  = mix_left;
               rsp_data_in.tilt_setpoint = setpoint_ff;
               rsp_data_in.active        = active_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      active_ff   <= active_in;
      angle_ff    <= angle_in;
      rate_ff     <= rate_in;
      thr_ff      <= thr_in;
      st_ff       <= st_in;
      e_ff        <= e_in;
      ediff_ff    <= ediff_in;
      ae_ff       <= ae_in;
      sum_abs_ff  <= sum_abs_in;
      sum_neg_ff  <= sum_neg_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         filt_ff         <= '0;
         spd_err_last_ff <= '0;
         spd_int_ff      <= '0;
         ang_err_last_ff <= '0;
         ang_int_ff      <= '0;
         drive_ff        <= '0;
         setpoint_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         filt_ff         <= filt_in;
         spd_err_last_ff <= spd_err_last_in;
         spd_int_ff      <= spd_int_in;
         ang_err_last_ff <= ang_err_last_in;
         ang_int_ff      <= ang_int_in;
         drive_ff        <= drive_in;
         setpoint_ff     <= setpoint_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // An out-of-window tick clears integrators and drive and goes straight to the mixer
   a_inactive_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && !active_now) |=>
      (state_ff == ST_MIX && drive_ff == 11'sd0 && spd_int_ff == 32'sd0 &&
       ang_int_ff == 40'sd0))
      else $error("inactive tick did not clear loop state");

   // The drive leaves the clamp stage within -499..500
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRV) |=> (drive_ff >= -11'sd499 && drive_ff <= 11'sd500))
      else $error("drive outside its clamp range");

   // The setpoint never exceeds the limit it was clamped to
   a_setpoint_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPC) |=>
      (32'(setpoint_ff) <= $signed(32'($past(spl))) &&
       32'(setpoint_ff) >= -$signed(32'($past(spl)))))
      else $error("setpoint outside its limit");

   // A held result is never overwritten: the sequencer waits in its last step
   a_mix_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX && rsp_valid_ff && rsp_stall) |=>
      (state_ff == ST_MIX && rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("output beat overwritten while stalled");
`endif

endmodule
